// File: src/dcr_pkg.sv
package dcr_pkg;

    localparam int CoordW  = 32;
    localparam int DiffW   = 33;
    localparam int MagW    = 33;
    localparam int SqW     = 66;
    localparam int DotW    = 68;
    localparam int RestW   = 31;
    localparam int MassW   = 24;
    localparam int MsumW   = 25;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef coord_t vec3_t [3];

    function automatic coord_t sat32(input logic signed [DiffW+1:0] v);
        logic signed [DiffW+1:0] hi;
        logic signed [DiffW+1:0] lo;
        begin
            hi = (DiffW+2)'(32'sh7FFF_FFFF);
            lo = -(DiffW+2)'(64'sh8000_0000);
            if (v > hi)
                sat32 = 32'sh7FFF_FFFF;
            else if (v < lo)
                sat32 = 32'sh8000_0000;
            else
                sat32 = v[CoordW-1:0];
        end
    endfunction

endpackage

// File: src/dcr_divider.sv
// Pipelined restoring divider: one quotient bit per stage.
module dcr_divider
    import dcr_pkg::*;
#(
    parameter int NUM_W  = 69,
    parameter int DEN_W  = 69,
    parameter int QBITS  = 17
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              out_valid,
    output logic [QBITS-1:0]  quo
);

    localparam int RW = DEN_W + 1;

    logic             v_reg   [QBITS];
    logic [RW-1:0]    r_reg   [QBITS];
    logic [DEN_W-1:0] d_reg   [QBITS];
    logic [QBITS-1:0] q_reg   [QBITS];

    genvar g;
    generate
        for (g = 0; g < QBITS; g++)
        begin : g_step
            logic             cur_v;
            logic [RW-1:0]    cur_r;
            logic [DEN_W-1:0] cur_d;
            logic [QBITS-1:0] cur_q;
            logic             ge;
            logic [RW-1:0]    rem;
            if (g == 0)
            begin : g_first
                assign cur_v = in_valid;
                assign cur_r = RW'(num);
                assign cur_d = den;
                assign cur_q = '0;
            end
            else
            begin : g_next
                assign cur_v = v_reg[g-1];
                assign cur_r = r_reg[g-1];
                assign cur_d = d_reg[g-1];
                assign cur_q = q_reg[g-1];
            end
            always_comb
            begin
                ge  = (cur_r >= RW'(cur_d)) && (cur_d != '0);
                rem = ge ? (cur_r - RW'(cur_d)) : cur_r;
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[g] <= 1'b0;
                else if (advance)
                    v_reg[g] <= cur_v;
            end
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    r_reg[g] <= {rem[RW-2:0], 1'b0};
                    d_reg[g] <= cur_d;
                    q_reg[g] <= {cur_q[QBITS-2:0], ge};
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QBITS-1];
    assign quo       = q_reg[QBITS-1];

endmodule

// File: src/distance_constraint_relax_core.sv
// Distance constraint relaxation, square-root free. One item per cycle in,
// one result per item out, in order. The stretch-factor and mass-weight
// dividers produce one quotient bit per stage. The whole pipe advances
// together; when the output register holds an unaccepted result, every
// stage holds. An item with zero inverse-mass sum passes its positions
// through with skipped set; coincident particles with zero rest length
// pass through with skipped low.
module distance_constraint_relax_core
    import dcr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [31:0]      pos_a_x,
    input  logic signed [31:0]      pos_a_y,
    input  logic signed [31:0]      pos_a_z,
    input  logic signed [31:0]      pos_b_x,
    input  logic signed [31:0]      pos_b_y,
    input  logic signed [31:0]      pos_b_z,
    input  logic [30:0]             rest_length,
    input  logic [23:0]             inv_mass_a,
    input  logic [23:0]             inv_mass_b,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      new_a_x,
    output logic signed [31:0]      new_a_y,
    output logic signed [31:0]      new_a_z,
    output logic signed [31:0]      new_b_x,
    output logic signed [31:0]      new_b_y,
    output logic signed [31:0]      new_b_z,
    output logic                    skipped
);

    localparam int QB   = FRAC_BITS + 1;
    localparam int NUMW = DotW + 1;
    localparam int WNW  = MassW + FRAC_BITS;
    localparam int KW   = QB;
    localparam int PW   = MagW + KW;

    logic advance;
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // Stage 1: differences, squares of magnitudes
    logic            s1_v_reg;
    vec3_t           s1_a_reg, s1_b_reg;
    logic [MagW-1:0] s1_mag_reg [3];
    logic            s1_neg_reg [3];
    logic [SqW-1:0]  s1_sq_reg [3];
    logic [61:0]     s1_rr_reg;
    logic [MassW-1:0] s1_ma_reg, s1_mb_reg;

    vec3_t pa, pb;
    assign pa[0] = pos_a_x; assign pa[1] = pos_a_y; assign pa[2] = pos_a_z;
    assign pb[0] = pos_b_x; assign pb[1] = pos_b_y; assign pb[2] = pos_b_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (advance)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [DiffW-1:0] d;
                logic [MagW-1:0] m;
                d = DiffW'(pb[i]) - DiffW'(pa[i]);
                m = d[DiffW-1] ? MagW'(-d) : MagW'(d);
                s1_a_reg[i]   <= pa[i];
                s1_b_reg[i]   <= pb[i];
                s1_mag_reg[i] <= m;
                s1_neg_reg[i] <= d[DiffW-1];
                s1_sq_reg[i]  <= SqW'(m) * SqW'(m);
            end
            s1_rr_reg <= 62'(rest_length) * 62'(rest_length);
            s1_ma_reg <= inv_mass_a;
            s1_mb_reg <= inv_mass_b;
        end
    end

    // Stage 2: dot product, inverse-mass sum and mass-weight dividends
    logic             s2_v_reg;
    logic [DotW-1:0]  s2_dd_reg;
    logic [61:0]      s2_rr_reg;
    logic [MsumW-1:0] s2_msum_reg;
    logic [WNW-1:0]   s2_wna_reg, s2_wnb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (advance)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_dd_reg   <= DotW'(s1_sq_reg[0]) + DotW'(s1_sq_reg[1]) + DotW'(s1_sq_reg[2]);
            s2_rr_reg   <= s1_rr_reg;
            s2_msum_reg <= MsumW'(s1_ma_reg) + MsumW'(s1_mb_reg);
            s2_wna_reg  <= WNW'(s1_ma_reg) << FRAC_BITS;
            s2_wnb_reg  <= WNW'(s1_mb_reg) << FRAC_BITS;
        end
    end

    logic            s3_v_reg;
    logic            s3_sneg_reg;
    logic [NUMW-1:0] s3_num_reg, s3_den_reg;
    logic [MsumW-1:0] s3_msum_reg;
    logic [WNW-1:0]  s3_wna_reg, s3_wnb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (advance)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            logic lt;
            lt = s2_dd_reg < DotW'(s2_rr_reg);
            s3_sneg_reg <= lt;
            s3_num_reg  <= lt ? NUMW'(DotW'(s2_rr_reg) - s2_dd_reg)
                              : NUMW'(s2_dd_reg - DotW'(s2_rr_reg));
            s3_den_reg  <= NUMW'(s2_dd_reg) + NUMW'(s2_rr_reg);
            s3_msum_reg <= s2_msum_reg;
            s3_wna_reg  <= s2_wna_reg;
            s3_wnb_reg  <= s2_wnb_reg;
        end
    end

    // Side data that rides alongside the dividers
    localparam int DLY = QB;
    logic            dl_sneg_reg [DLY];
    logic [MsumW-1:0] dl_msum_reg [DLY];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dl_sneg_reg[0] <= s3_sneg_reg;
            dl_msum_reg[0] <= s3_msum_reg;
            for (int i = 1; i < DLY; i++)
            begin
                dl_sneg_reg[i] <= dl_sneg_reg[i-1];
                dl_msum_reg[i] <= dl_msum_reg[i-1];
            end
        end
    end

    // Positions and magnitudes up to the factor stage (QB + 3 stages past stage 1)
    localparam int PD = QB + 3;
    vec3_t           pd_a_reg [PD], pd_b_reg [PD];
    logic [MagW-1:0] pd_mag_reg [PD][3];
    logic            pd_neg_reg [PD][3];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pd_a_reg[0]   <= s1_a_reg;
            pd_b_reg[0]   <= s1_b_reg;
            pd_mag_reg[0] <= s1_mag_reg;
            pd_neg_reg[0] <= s1_neg_reg;
            for (int i = 1; i < PD; i++)
            begin
                pd_a_reg[i]   <= pd_a_reg[i-1];
                pd_b_reg[i]   <= pd_b_reg[i-1];
                pd_mag_reg[i] <= pd_mag_reg[i-1];
                pd_neg_reg[i] <= pd_neg_reg[i-1];
            end
        end
    end

    logic            sd_v;
    logic [QB-1:0]   s_q;
    logic            wa_v, wb_v;
    logic [QB-1:0]   wa_q, wb_q;

    // Stretch factor: floor(num * 2^F / den), QB quotient bits
    dcr_divider #(.NUM_W(NUMW), .DEN_W(NUMW), .QBITS(QB)) u_sdiv (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(s3_v_reg),
        .num(s3_num_reg), .den(s3_den_reg),
        .out_valid(sd_v), .quo(s_q));

    // Mass weights: dividend ma<<F, quotient at most 2^F
    dcr_divider #(.NUM_W(WNW), .DEN_W(WNW), .QBITS(QB)) u_wadiv (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(s3_v_reg),
        .num(s3_wna_reg >> FRAC_BITS), .den(WNW'(s3_msum_reg)),
        .out_valid(wa_v), .quo(wa_q));
    dcr_divider #(.NUM_W(WNW), .DEN_W(WNW), .QBITS(QB)) u_wbdiv (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(s3_v_reg),
        .num(s3_wnb_reg >> FRAC_BITS), .den(WNW'(s3_msum_reg)),
        .out_valid(wb_v), .quo(wb_q));

    // Stage: factors k = s*w >> F
    logic            k_v_reg;
    logic [KW-1:0]   ka_reg, kb_reg;
    logic            k_sneg_reg;
    logic            k_skip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_v_reg <= 1'b0;
        else if (advance)
            k_v_reg <= sd_v && wa_v && wb_v;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ka_reg     <= KW'((2*QB)'(s_q) * (2*QB)'(wa_q) >> FRAC_BITS);
            kb_reg     <= KW'((2*QB)'(s_q) * (2*QB)'(wb_q) >> FRAC_BITS);
            k_sneg_reg <= dl_sneg_reg[DLY-1];
            k_skip_reg <= dl_msum_reg[DLY-1] == '0;
        end
    end

    // Stage: per-axis correction products
    logic            c_v_reg;
    logic [PW-FRAC_BITS-1:0] ca_reg [3], cb_reg [3];
    logic            c_neg_reg [3];
    logic            c_skip_reg;
    vec3_t           c_a_reg, c_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (advance)
            c_v_reg <= k_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ca_reg[i] <= (PW-FRAC_BITS)'((PW'(pd_mag_reg[PD-1][i]) * PW'(ka_reg))
                                            >> FRAC_BITS);
                cb_reg[i] <= (PW-FRAC_BITS)'((PW'(pd_mag_reg[PD-1][i]) * PW'(kb_reg))
                                            >> FRAC_BITS);
                c_neg_reg[i] <= pd_neg_reg[PD-1][i] != k_sneg_reg;
            end
            c_skip_reg <= k_skip_reg;
            c_a_reg    <= pd_a_reg[PD-1];
            c_b_reg    <= pd_b_reg[PD-1];
        end
    end

    // Output register: apply, saturate
    vec3_t na_reg, nb_reg;
    logic  skip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (advance)
            out_valid <= c_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [DiffW+1:0] ea, eb, va, vb;
                ea = c_neg_reg[i] ? -(DiffW+2)'(ca_reg[i]) : (DiffW+2)'(ca_reg[i]);
                eb = c_neg_reg[i] ? -(DiffW+2)'(cb_reg[i]) : (DiffW+2)'(cb_reg[i]);
                va = (DiffW+2)'(c_a_reg[i]) + ea;
                vb = (DiffW+2)'(c_b_reg[i]) - eb;
                na_reg[i] <= c_skip_reg ? c_a_reg[i] : sat32(va);
                nb_reg[i] <= c_skip_reg ? c_b_reg[i] : sat32(vb);
            end
            skip_reg <= c_skip_reg;
        end
    end

    assign new_a_x = na_reg[0];
    assign new_a_y = na_reg[1];
    assign new_a_z = na_reg[2];
    assign new_b_x = nb_reg[0];
    assign new_b_y = nb_reg[1];
    assign new_b_z = nb_reg[2];
    assign skipped = skip_reg;

endmodule

// File: bench/dcr_checker.sv
module dcr_checker
    import dcr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] pos_a_x,
    input  logic signed [31:0] pos_a_y,
    input  logic signed [31:0] pos_a_z,
    input  logic signed [31:0] pos_b_x,
    input  logic signed [31:0] pos_b_y,
    input  logic signed [31:0] pos_b_z,
    input  logic [30:0]        rest_length,
    input  logic [23:0]        inv_mass_a,
    input  logic [23:0]        inv_mass_b,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] new_a_x,
    input  logic signed [31:0] new_a_y,
    input  logic signed [31:0] new_a_z,
    input  logic signed [31:0] new_b_x,
    input  logic signed [31:0] new_b_y,
    input  logic signed [31:0] new_b_z,
    input  logic               skipped,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [31:0] ax, ay, az, bx, by, bz;
        logic               skip;
    } relaxed_t;

    relaxed_t relaxed_q[$];

    function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
        if (v > 96'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -96'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Signed correction along one axis: |d|*k >> F, sign of d times sign of s.
    function automatic logic signed [95:0] axis_corr(input logic signed [32:0] d,
                                                      input logic s_neg,
                                                      input logic [63:0] k);
        logic [32:0]  mag;
        logic [95:0]  c;
        mag = d[32] ? 33'(-d) : 33'(d);
        c = ({63'd0, mag} * {32'd0, k}) >> FRAC_BITS;
        return (d[32] != s_neg) ? -$signed(c) : $signed(c);
    endfunction

    function automatic relaxed_t relax(input logic signed [31:0] a [3],
                                        input logic signed [31:0] b [3],
                                        input logic [30:0] r,
                                        input logic [23:0] ma,
                                        input logic [23:0] mb);
        relaxed_t res;
        logic signed [32:0] d [3];
        logic [24:0]  msum;
        logic [127:0] dd, rr, num, den, m;
        logic [63:0]  s, wa, wb, ka, kb;
        logic         s_neg;
        logic signed [31:0] na [3], nb [3];
        for (int i = 0; i < 3; i++)
        begin
            d[i] = 33'(b[i]) - 33'(a[i]);
            na[i] = a[i];
            nb[i] = b[i];
        end
        msum = 25'(ma) + 25'(mb);
        if (msum != 0)
        begin
            dd = 0;
            for (int i = 0; i < 3; i++)
            begin
                m = d[i][32] ? 128'(-d[i]) : 128'(d[i]);
                dd += m * m;
            end
            rr = 128'(r) * 128'(r);
            s_neg = dd < rr;
            num = s_neg ? rr - dd : dd - rr;
            den = dd + rr;
            s = 0;
            if (den != 0)
                s = 64'((num << FRAC_BITS) / den);
            wa = (64'(ma) << FRAC_BITS) / 64'(msum);
            wb = (64'(mb) << FRAC_BITS) / 64'(msum);
            ka = (s * wa) >> FRAC_BITS;
            kb = (s * wb) >> FRAC_BITS;
            for (int i = 0; i < 3; i++)
            begin
                na[i] = clamp32(96'(a[i]) + axis_corr(d[i], s_neg, ka));
                nb[i] = clamp32(96'(b[i]) - axis_corr(d[i], s_neg, kb));
            end
        end
        res.ax = na[0]; res.ay = na[1]; res.az = na[2];
        res.bx = nb[0]; res.by = nb[1]; res.bz = nb[2];
        res.skip = (msum == 0);
        return res;
    endfunction

    assign pending = relaxed_q.size();

    always @(posedge clk)
    begin
        relaxed_t exp_r;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                a = '{pos_a_x, pos_a_y, pos_a_z};
                b = '{pos_b_x, pos_b_y, pos_b_z};
                relaxed_q.push_back(relax(a, b, rest_length, inv_mass_a, inv_mass_b));
            end
            if (out_valid && out_ready)
            begin
                if (relaxed_q.size() == 0)
                begin
                    $error("result with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_r = relaxed_q.pop_front();
                    if (new_a_x !== exp_r.ax) begin $error("new_a_x exp %0d got %0d", exp_r.ax, new_a_x); fail_count++; end
                    if (new_a_y !== exp_r.ay) begin $error("new_a_y exp %0d got %0d", exp_r.ay, new_a_y); fail_count++; end
                    if (new_a_z !== exp_r.az) begin $error("new_a_z exp %0d got %0d", exp_r.az, new_a_z); fail_count++; end
                    if (new_b_x !== exp_r.bx) begin $error("new_b_x exp %0d got %0d", exp_r.bx, new_b_x); fail_count++; end
                    if (new_b_y !== exp_r.by) begin $error("new_b_y exp %0d got %0d", exp_r.by, new_b_y); fail_count++; end
                    if (new_b_z !== exp_r.bz) begin $error("new_b_z exp %0d got %0d", exp_r.bz, new_b_z); fail_count++; end
                    if (skipped !== exp_r.skip) begin $error("skipped exp %0d got %0d", exp_r.skip, skipped); fail_count++; end
                end
            end
        end
        else
            fail_count = 0;
    end

endmodule

// File: bench/tb.sv
module tb;
    import dcr_pkg::*;

    localparam int LATENCY = 23;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] pos_a_x, pos_a_y, pos_a_z;
    logic signed [31:0] pos_b_x, pos_b_y, pos_b_z;
    logic [30:0]        rest_length;
    logic [23:0]        inv_mass_a, inv_mass_b;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] new_a_x, new_a_y, new_a_z;
    logic signed [31:0] new_b_x, new_b_y, new_b_z;
    logic               skipped;
    int                 fail_count;
    int                 pending;

    // Receiver modes: random stalls, or a long hold-off to back the pipe up.
    logic               hold_off;
    logic               stim_done;
    int                 rx_wait;

    distance_constraint_relax_core u_dut (.*);

    dcr_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Random 32-bit coordinate; mostly near-field so the stretch is meaningful,
    // sometimes full range to hit saturation.
    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    function automatic logic [23:0] rand_mass();
        case ($urandom_range(0, 7))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until accepted; drop valid only for a gap.
    task automatic send(input logic signed [31:0] ax, ay, az, bx, by, bz,
                        input logic [30:0] r, input logic [23:0] ma, mb);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pos_a_x     <= ax; pos_a_y <= ay; pos_a_z <= az;
        pos_b_x     <= bx; pos_b_y <= by; pos_b_z <= bz;
        rest_length <= r;
        inv_mass_a  <= ma;
        inv_mass_b  <= mb;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random(input int mode);
        logic signed [31:0] ax, ay, az;
        logic [30:0] r;
        ax = rand_coord(mode);
        ay = rand_coord(mode);
        az = rand_coord(mode);
        r = (mode == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0010_0000));
        if ($urandom_range(0, 15) == 0)
            send(ax, ay, az, ax, ay, az, $urandom_range(0, 1) ? 31'd0 : r,
                 rand_mass(), rand_mass());
        else
            send(ax, ay, az, ax + rand_coord(1 + mode % 2), ay + rand_coord(1),
                 az + rand_coord(2), r, rand_mass(), rand_mass());
    endtask

    // Receiver: draw a random wait after each accepted item, except during a long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else if (hold_off)
            out_ready <= 1'b0;
        else if (out_valid && out_ready)
        begin
            gap = $urandom_range(0, 7);
            rx_wait   <= gap;
            out_ready <= (gap == 0);
        end
        else if (rx_wait != 0)
        begin
            rx_wait   <= rx_wait - 1;
            out_ready <= (rx_wait == 1);
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        hold_off = 1'b0;
        wait (stim_done === 1'b0);
        repeat (300) @(posedge clk);
        hold_off <= 1'b1;
        repeat (120) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        stim_done   = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pos_a_x = 0; pos_a_y = 0; pos_a_z = 0;
        pos_b_x = 0; pos_b_y = 0; pos_b_z = 0;
        rest_length = 0;
        inv_mass_a  = 0;
        inv_mass_b  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: both fixed, coincident with zero length, extremes.
        send(32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0, 31'h10000, 24'd0, 24'd0);
        send(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd5, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sd5, 31'h7FFF_FFFF, 24'd0, 24'd0);
        send(32'sh1234, 32'sh1234, 32'sh1234, 32'sh1234, 32'sh1234, 32'sh1234, 31'd0,
             24'h1_0000, 24'h1_0000);
        send(32'sh1234, -32'sh55, 32'sd0, 32'sh1234, -32'sh55, 32'sd0, 31'h7FFF_FFFF,
             24'hFF_FFFF, 24'd1);
        send(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd0, 24'hFF_FFFF, 24'hFF_FFFF);
        send(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
             32'sh8000_0000, 32'sh8000_0000, 31'd1, 24'h1, 24'h0);
        send(32'sd0, 32'sd0, 32'sd0, 32'sh1_0000, 32'sd0, 32'sd0, 31'h7FFF_FFFF,
             24'h0, 24'hFF_FFFF);
        send(32'sd0, 32'sd0, 32'sd0, 32'sh2_0000, 32'sd0, 32'sd0, 31'h1_0000,
             24'h1_0000, 24'h1_0000);
        send(32'sd0, 32'sd0, 32'sd0, 32'sh0_8000, 32'sh0_8000, 32'sd0, 31'h1_0000,
             24'h1_0000, 24'h3_0000);
        send(-32'sh3_0000, 32'sd7, 32'sd0, 32'sh3_0000, 32'sd7, 32'sd0, 31'h6_0000,
             24'h8_0000, 24'h8_0000);
        send(32'sh7FFF_0000, 32'sd0, 32'sd0, 32'sh8000_0000, 32'sd0, 32'sd0, 31'd1,
             24'hFF_FFFF, 24'hFF_FFFF);
        in_valid <= 1'b0;

        // Pause until everything drains.
        @(posedge clk);
        wait (pending == 0);

        for (int n = 0; n < 1300; n++)
            send_random(n % 5 == 0 ? 0 : (n % 2) + 1);
        in_valid <= 1'b0;

        stim_done = 1'b1;
        @(posedge clk);
        wait (pending == 0);
        repeat (LATENCY * 2) @(posedge clk);
        if (fail_count == 0)
            $display("distance_constraint_relax_core verification clean");
        else
            $display("distance_constraint_relax_core verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("distance_constraint_relax_core verification failed");
        $finish;
    end

endmodule
